[src/scs_pkg.sv]
// ----------------------------------------------------------------------------
// scs_pkg: shared types and constants of the selective color sepia unit
// register indexes, keep flags and fixed-point sepia coefficients
// ----------------------------------------------------------------------------
package scs_pkg;

   localparam int unsigned CHAN_W      = 8;
   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 1;

   // register indexes of the configuration port
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_KEEP_RED     = 3'd0,
      CSR_KEEP_GREEN   = 3'd1,
      CSR_KEEP_BLUE    = 3'd2,
      CSR_KEEP_MAGENTA = 3'd3,
      CSR_KEEP_YELLOW  = 3'd4,
      CSR_KEEP_CYAN    = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic red;
      logic green;
      logic blue;
      logic magenta;
      logic yellow;
      logic cyan;
   } keep_type;

   localparam keep_type KEEP_RESET = '{default: 1'b1};

   // floor(s / 1000) == (s * RECIP) >> RECIP_SHIFT for every sum the matrix can give
   localparam int unsigned RECIP_SHIFT = 28;
   localparam int unsigned RECIP       = 268436;
   localparam int unsigned COEF_W      = RECIP_SHIFT;
   localparam int unsigned ACC_W       = RECIP_SHIFT + 9;

   // each sepia weight pre-scaled by the reciprocal of 1000
   localparam logic [COEF_W-1:0] SEPIA_RR = COEF_W'(393 * RECIP);
   localparam logic [COEF_W-1:0] SEPIA_RG = COEF_W'(739 * RECIP);
   localparam logic [COEF_W-1:0] SEPIA_RB = COEF_W'(189 * RECIP);
   localparam logic [COEF_W-1:0] SEPIA_GR = COEF_W'(349 * RECIP);
   localparam logic [COEF_W-1:0] SEPIA_GG = COEF_W'(656 * RECIP);
   localparam logic [COEF_W-1:0] SEPIA_GB = COEF_W'(168 * RECIP);
   localparam logic [COEF_W-1:0] SEPIA_BR = COEF_W'(272 * RECIP);
   localparam logic [COEF_W-1:0] SEPIA_BG = COEF_W'(504 * RECIP);
   localparam logic [COEF_W-1:0] SEPIA_BB = COEF_W'(131 * RECIP);

endpackage

[src/scs_req_if.sv]
// ----------------------------------------------------------------------------
// scs_req_if: pixel input channel
// valid/ready handshake carrying one rgb888 pixel
// ----------------------------------------------------------------------------
interface scs_req_if;
   logic                        valid;
   logic                        ready;
   logic [scs_pkg::CHAN_W-1:0]  red_in;
   logic [scs_pkg::CHAN_W-1:0]  green_in;
   logic [scs_pkg::CHAN_W-1:0]  blue_in;

   modport source (output valid, output red_in, output green_in, output blue_in,
                   input ready);
   modport sink   (input valid, input red_in, input green_in, input blue_in,
                   output ready);
endinterface

[src/scs_rsp_if.sv]
// ----------------------------------------------------------------------------
// scs_rsp_if: pixel result channel
// valid/ready handshake carrying one toned or kept pixel
// ----------------------------------------------------------------------------
interface scs_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [scs_pkg::CHAN_W-1:0]  red_out;
   logic [scs_pkg::CHAN_W-1:0]  green_out;
   logic [scs_pkg::CHAN_W-1:0]  blue_out;
   logic                        kept;

   modport source (output valid, output red_out, output green_out, output blue_out,
                   output kept, input ready);
   modport sink   (input valid, input red_out, input green_out, input blue_out,
                   input kept, output ready);
endinterface

[src/selective_color_sepia_unit.sv]
// ----------------------------------------------------------------------------
// selective_color_sepia_unit: sepia toning with selective color keep
// pixels in an enabled color class pass unchanged, all others are toned
// ----------------------------------------------------------------------------
//
//  channel | direction | transfer contents
//  --------+-----------+-----------------------------------------------
//  req_if  | in        | red_in, green_in, blue_in (one pixel)
//  rsp_if  | out       | red_out, green_out, blue_out, kept
//  csr_*   | in        | write enable, register index, 1-bit data
//
//  one pixel per cycle sustained while rsp is not stalled; each pixel
//  passes the input register, then the result register, which drives
//  rsp valid; the class tests and the fused matrix/divide fit between
//  those registers
//  reset clears both valid flags and sets every keep flag to 1
//  a stalled rsp holds its register; req_ready follows the free slot, so a
//  full pipe still takes a pixel in the cycle the result leaves
//
module selective_color_sepia_unit (
   input  logic                                clock,
   input  logic                                reset,
   scs_req_if.sink                             req_if,
   scs_rsp_if.source                           rsp_if,
   input  logic                                csr_wr_en,
   input  logic [scs_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [scs_pkg::CSR_DATA_W-1:0]      csr_wr_data
);

   localparam int unsigned CW    = scs_pkg::CHAN_W;
   localparam int unsigned CMP_W = CW + 4;   // holds 9 * 255

   // a > 1.8 * b, exactly
   function automatic logic above(input logic [CW-1:0] a, input logic [CW-1:0] b);
      return (CMP_W'(a) * CMP_W'(5)) > (CMP_W'(b) * CMP_W'(9));
   endfunction

   // a <= 1.8 * b, exactly
   function automatic logic near(input logic [CW-1:0] a, input logic [CW-1:0] b);
      return (CMP_W'(a) * CMP_W'(5)) <= (CMP_W'(b) * CMP_W'(9));
   endfunction

   function automatic logic primary(input logic [CW-1:0] a, input logic [CW-1:0] o1,
                                    input logic [CW-1:0] o2);
      return above(a, o1) && above(a, o2);
   endfunction

   // one of p and q well above l, the other above l, and the two close to each other
   function automatic logic secondary(input logic [CW-1:0] p, input logic [CW-1:0] q,
                                      input logic [CW-1:0] l);
      logic lead;
      lead = (above(p, l) && (q > l)) || (above(q, l) && (p > l));
      return lead && near(p, q) && near(q, p);
   endfunction

   // weighted sum already scaled by the 1/1000 reciprocal, then saturated
   function automatic logic [CW-1:0] tone(
      input logic [CW-1:0] r, input logic [CW-1:0] g, input logic [CW-1:0] b,
      input logic [scs_pkg::COEF_W-1:0] kr, input logic [scs_pkg::COEF_W-1:0] kg,
      input logic [scs_pkg::COEF_W-1:0] kb);
      logic [scs_pkg::ACC_W-1:0] acc;
      logic [8:0]                quo;
      acc = scs_pkg::ACC_W'(r) * scs_pkg::ACC_W'(kr)
          + scs_pkg::ACC_W'(g) * scs_pkg::ACC_W'(kg)
          + scs_pkg::ACC_W'(b) * scs_pkg::ACC_W'(kb);
      quo = acc[scs_pkg::ACC_W-1:scs_pkg::RECIP_SHIFT];
      return quo[8] ? {CW{1'b1}} : quo[CW-1:0];
   endfunction

   // keep flags
   scs_pkg::keep_type keep_ff, keep_in;

   // input register
   logic          pix_valid_ff, pix_valid_in;
   logic [CW-1:0] red_ff, green_ff, blue_ff;
   logic [CW-1:0] red_in, green_in, blue_in;

   // result register
   logic          rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0] red_out_ff, green_out_ff, blue_out_ff;
   logic [CW-1:0] red_out_in, green_out_in, blue_out_in;
   logic          kept_ff, kept_in;

   logic          rsp_free;     // result register can load this cycle
   logic          req_take;     // req transfer this cycle
   logic          keep_pix;
   logic          grey;

   // configuration decode, out-of-range indexes are dropped
   always_comb begin
      keep_in = keep_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            scs_pkg::CSR_KEEP_RED:     keep_in.red     = csr_wr_data[0];
            scs_pkg::CSR_KEEP_GREEN:   keep_in.green   = csr_wr_data[0];
            scs_pkg::CSR_KEEP_BLUE:    keep_in.blue    = csr_wr_data[0];
            scs_pkg::CSR_KEEP_MAGENTA: keep_in.magenta = csr_wr_data[0];
            scs_pkg::CSR_KEEP_YELLOW:  keep_in.yellow  = csr_wr_data[0];
            scs_pkg::CSR_KEEP_CYAN:    keep_in.cyan    = csr_wr_data[0];
            default:                   keep_in = keep_ff;
         endcase
      end
   end

   // flow control
   assign rsp_free      = !rsp_valid_ff || rsp_if.ready;
   assign req_if.ready  = !pix_valid_ff || rsp_free;
   assign req_take      = req_if.valid && req_if.ready;

   always_comb begin
      pix_valid_in = pix_valid_ff;
      red_in       = red_ff;
      green_in     = green_ff;
      blue_in      = blue_ff;
      if (req_if.ready) begin
         pix_valid_in = req_if.valid;
      end
      if (req_take) begin
         red_in   = req_if.red_in;
         green_in = req_if.green_in;
         blue_in  = req_if.blue_in;
      end
   end

   // color classes, grey only when all three primaries are kept
   assign grey = keep_ff.red && keep_ff.green && keep_ff.blue
              && near(red_ff, green_ff) && near(red_ff, blue_ff)
              && near(green_ff, red_ff) && near(green_ff, blue_ff)
              && near(blue_ff, red_ff)  && near(blue_ff, green_ff);

   assign keep_pix = (keep_ff.red     && primary(red_ff, green_ff, blue_ff))
                  || (keep_ff.green   && primary(green_ff, red_ff, blue_ff))
                  || (keep_ff.blue    && primary(blue_ff, red_ff, green_ff))
                  || (keep_ff.magenta && secondary(red_ff, blue_ff, green_ff))
                  || (keep_ff.yellow  && secondary(red_ff, green_ff, blue_ff))
                  || (keep_ff.cyan    && secondary(blue_ff, green_ff, red_ff))
                  || grey;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      red_out_in   = red_out_ff;
      green_out_in = green_out_ff;
      blue_out_in  = blue_out_ff;
      kept_in      = kept_ff;
      if (rsp_free) begin
         rsp_valid_in = pix_valid_ff;
      end
      if (rsp_free && pix_valid_ff) begin
         kept_in = keep_pix;
         if (keep_pix) begin
            red_out_in   = red_ff;
            green_out_in = green_ff;
            blue_out_in  = blue_ff;
         end else begin
            red_out_in   = tone(red_ff, green_ff, blue_ff,
                                scs_pkg::SEPIA_RR, scs_pkg::SEPIA_RG, scs_pkg::SEPIA_RB);
            green_out_in = tone(red_ff, green_ff, blue_ff,
                                scs_pkg::SEPIA_GR, scs_pkg::SEPIA_GG, scs_pkg::SEPIA_GB);
            blue_out_in  = tone(red_ff, green_ff, blue_ff,
                                scs_pkg::SEPIA_BR, scs_pkg::SEPIA_BG, scs_pkg::SEPIA_BB);
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         keep_ff      <= scs_pkg::KEEP_RESET;
         pix_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         keep_ff      <= keep_in;
         pix_valid_ff <= pix_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      red_ff       <= red_in;
      green_ff     <= green_in;
      blue_ff      <= blue_in;
      red_out_ff   <= red_out_in;
      green_out_ff <= green_out_in;
      blue_out_ff  <= blue_out_in;
      kept_ff      <= kept_in;
   end

   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.red_out   = red_out_ff;
   assign rsp_if.green_out = green_out_ff;
   assign rsp_if.blue_out  = blue_out_ff;
   assign rsp_if.kept      = kept_ff;

endmodule

[sim/tb_selective_color_sepia_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_selective_color_sepia_unit: self-checking bench for the sepia unit
// drives pixels through a valid/ready channel under varying keep settings
// and compares every toned or kept pixel with an in-bench prediction
// ----------------------------------------------------------------------------
module tb_selective_color_sepia_unit;

   // run length and timeout
   localparam int unsigned PHASE_COUNT     = 8;
   localparam int unsigned PIXELS_PER_PHASE = 225;
   localparam int unsigned CYCLE_LIMIT     = 400000;
   localparam int unsigned TAIL_CYCLES     = 4;

   // indexes past the last register, writes there must change nothing
   localparam logic [scs_pkg::CSR_INDEX_W-1:0] CSR_SPARE_LOW  = 3'd6;
   localparam logic [scs_pkg::CSR_INDEX_W-1:0] CSR_SPARE_HIGH = 3'd7;

   typedef struct packed {
      logic [scs_pkg::CHAN_W-1:0] red;
      logic [scs_pkg::CHAN_W-1:0] green;
      logic [scs_pkg::CHAN_W-1:0] blue;
   } pixel_type;

   typedef struct packed {
      logic [scs_pkg::CHAN_W-1:0] red;
      logic [scs_pkg::CHAN_W-1:0] green;
      logic [scs_pkg::CHAN_W-1:0] blue;
      logic                       kept;
   } shade_type;

   // keeps the keep flags in step with the block and queues the expected pixels
   class sepia_scoreboard_type;
      scs_pkg::keep_type keep;
      shade_type         pending[$];
      int unsigned       mismatches;

      function new();
         keep       = scs_pkg::KEEP_RESET;
         mismatches = 0;
      endfunction

      // a > 1.8 * b, exact in integers
      static function bit exceeds(int unsigned a, int unsigned b);
         return 5 * a > 9 * b;
      endfunction

      // a <= 1.8 * b
      static function bit ratio_ok(int unsigned a, int unsigned b);
         return 5 * a <= 9 * b;
      endfunction

      // one of p and q well above l, the other above l, and the two close to each other
      static function bit pair_class(int unsigned p, int unsigned q, int unsigned l);
         return ((exceeds(p, l) && q > l) || (exceeds(q, l) && p > l))
                && ratio_ok(p, q) && ratio_ok(q, p);
      endfunction

      function void set_keep(logic [scs_pkg::CSR_INDEX_W-1:0] index, logic value);
         case (index)
            scs_pkg::CSR_KEEP_RED:     keep.red     = value;
            scs_pkg::CSR_KEEP_GREEN:   keep.green   = value;
            scs_pkg::CSR_KEEP_BLUE:    keep.blue    = value;
            scs_pkg::CSR_KEEP_MAGENTA: keep.magenta = value;
            scs_pkg::CSR_KEEP_YELLOW:  keep.yellow  = value;
            scs_pkg::CSR_KEEP_CYAN:    keep.cyan    = value;
            default: ;
         endcase
      endfunction

      function void note_pixel(pixel_type px);
         int unsigned r, g, b, sr, sg, sb;
         bit          hit;
         shade_type   want;
         r   = px.red;
         g   = px.green;
         b   = px.blue;
         hit = 1'b0;
         if (keep.red && exceeds(r, g) && exceeds(r, b)) hit = 1'b1;
         if (keep.green && exceeds(g, r) && exceeds(g, b)) hit = 1'b1;
         if (keep.blue && exceeds(b, r) && exceeds(b, g)) hit = 1'b1;
         if (keep.magenta && pair_class(r, b, g)) hit = 1'b1;
         if (keep.yellow && pair_class(r, g, b)) hit = 1'b1;
         if (keep.cyan && pair_class(b, g, r)) hit = 1'b1;
         // grey/brown needs all three primaries enabled
         if (keep.red && keep.green && keep.blue &&
             ratio_ok(r, g) && ratio_ok(r, b) && ratio_ok(g, r) &&
             ratio_ok(g, b) && ratio_ok(b, r) && ratio_ok(b, g))
            hit = 1'b1;
         if (hit) begin
            want.red   = px.red;
            want.green = px.green;
            want.blue  = px.blue;
            want.kept  = 1'b1;
         end else begin
            sr = (393 * r + 739 * g + 189 * b) / 1000;
            sg = (349 * r + 656 * g + 168 * b) / 1000;
            sb = (272 * r + 504 * g + 131 * b) / 1000;
            want.red   = (sr > 255) ? 8'd255 : sr[7:0];
            want.green = (sg > 255) ? 8'd255 : sg[7:0];
            want.blue  = (sb > 255) ? 8'd255 : sb[7:0];
            want.kept  = 1'b0;
         end
         pending.push_back(want);
      endfunction

      function void check_pixel(shade_type got);
         shade_type want;
         if (pending.size() == 0) begin
            $error("unexpected result transfer: red_out %0d green_out %0d %s %0d kept %0d",
                   got.red, got.green, "blue_out", got.blue, got.kept);
            mismatches++;
            return;
         end
         want = pending.pop_front();
         if (got.red !== want.red) begin
            $error("red_out: expected %0d, actual %0d", want.red, got.red);
            mismatches++;
         end
         if (got.green !== want.green) begin
            $error("green_out: expected %0d, actual %0d", want.green, got.green);
            mismatches++;
         end
         if (got.blue !== want.blue) begin
            $error("blue_out: expected %0d, actual %0d", want.blue, got.blue);
            mismatches++;
         end
         if (got.kept !== want.kept) begin
            $error("kept: expected %0d, actual %0d", want.kept, got.kept);
            mismatches++;
         end
      endfunction
   endclass

   logic                            clock = 1'b0;
   logic                            reset;
   logic                            csr_wr_en;
   logic [scs_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [scs_pkg::CSR_DATA_W-1:0]  csr_wr_data;

   scs_req_if req_ch ();
   scs_rsp_if rsp_ch ();

   sepia_scoreboard_type board;
   int unsigned          sender_idle_pct;
   int unsigned          receiver_stall_pct;
   int unsigned          cycle_count = 0;

   selective_color_sepia_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_ch),
      .rsp_if      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   // 10 ns clock
   always #5 clock = ~clock;

   // timeout guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // receiver: random backpressure on the result channel
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   // result monitor: every result transfer is checked against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         board.check_pixel({rsp_ch.red_out, rsp_ch.green_out, rsp_ch.blue_out,
                            rsp_ch.kept});
      end
   end

   // one register write, the enable stays high until the caller lowers it
   task automatic csr_write(input logic [scs_pkg::CSR_INDEX_W-1:0] index,
                            input logic value);
      csr_wr_en   <= 1'b1;
      csr_index   <= index;
      csr_wr_data <= value;
      @(posedge clock);
      board.set_keep(index, value);
   endtask

   // writes all six keep flags plus both spare indexes, only while idle
   task automatic write_keep(input scs_pkg::keep_type setting);
      csr_write(scs_pkg::CSR_KEEP_RED, setting.red);
      csr_write(CSR_SPARE_LOW, 1'($urandom_range(1)));
      csr_write(scs_pkg::CSR_KEEP_GREEN, setting.green);
      csr_write(scs_pkg::CSR_KEEP_BLUE, setting.blue);
      csr_write(scs_pkg::CSR_KEEP_MAGENTA, setting.magenta);
      csr_write(CSR_SPARE_HIGH, 1'($urandom_range(1)));
      csr_write(scs_pkg::CSR_KEEP_YELLOW, setting.yellow);
      csr_write(scs_pkg::CSR_KEEP_CYAN, setting.cyan);
      csr_wr_en <= 1'b0;
   endtask

   // offers one pixel, with random idle cycles ahead of it, and waits for the transfer
   task automatic send_pixel(input logic [scs_pkg::CHAN_W-1:0] r,
                             input logic [scs_pkg::CHAN_W-1:0] g,
                             input logic [scs_pkg::CHAN_W-1:0] b);
      while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.red_in   <= r;
      req_ch.green_in <= g;
      req_ch.blue_in  <= b;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      board.note_pixel({r, g, b});
   endtask

   // stop offering pixels and let every outstanding result come back
   task automatic drain_results();
      req_ch.valid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
   endtask

   // pixels shaped to land in and around the color classes
   function automatic pixel_type random_pixel();
      int unsigned hi, lo, v0, v1, v2;
      pixel_type   px;
      case ($urandom_range(5))
         0: begin
            // anything at all
            v0 = $urandom_range(255);
            v1 = $urandom_range(255);
            v2 = $urandom_range(255);
         end
         1: begin
            // one dominant channel
            hi = $urandom_range(255);
            v0 = hi;
            v1 = $urandom_range((hi * 5) / 9 + 2);
            v2 = $urandom_range((hi * 5) / 9 + 2);
         end
         2: begin
            // two close channels over a low one
            hi = $urandom_range(20, 255);
            lo = $urandom_range((hi * 5) / 9, hi);
            v0 = hi;
            v1 = lo;
            v2 = $urandom_range((lo * 5) / 9 + 2);
         end
         3: begin
            // a pair sitting on the 1.8 ratio edge
            v1 = $urandom_range(141);
            v0 = (v1 * 9) / 5 + $urandom_range(1);
            v2 = $urandom_range(255);
         end
         4: begin
            // near-grey, all channels close
            hi = $urandom_range(255);
            v0 = hi;
            v1 = $urandom_range((hi * 5) / 9, hi);
            v2 = $urandom_range((hi * 5) / 9, hi);
         end
         default: begin
            // bright pixels for sepia saturation
            v0 = $urandom_range(160, 255);
            v1 = $urandom_range(160, 255);
            v2 = $urandom_range(255);
         end
      endcase
      if (v0 > 255) v0 = 255;
      if (v1 > 255) v1 = 255;
      if (v2 > 255) v2 = 255;
      // spread the roles over the three channels
      case ($urandom_range(5))
         0: px = {v0[7:0], v1[7:0], v2[7:0]};
         1: px = {v0[7:0], v2[7:0], v1[7:0]};
         2: px = {v1[7:0], v0[7:0], v2[7:0]};
         3: px = {v1[7:0], v2[7:0], v0[7:0]};
         4: px = {v2[7:0], v0[7:0], v1[7:0]};
         default: px = {v2[7:0], v1[7:0], v0[7:0]};
      endcase
      return px;
   endfunction

   initial begin
      int unsigned       phase;
      int unsigned       n;
      scs_pkg::keep_type setting;
      pixel_type         px;

      reset           = 1'b1;
      csr_wr_en       = 1'b0;
      csr_index       = scs_pkg::CSR_KEEP_RED;
      csr_wr_data     = 1'b0;
      req_ch.valid    = 1'b0;
      req_ch.red_in   = '0;
      req_ch.green_in = '0;
      req_ch.blue_in  = '0;
      board           = new();
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed pixels under the reset keep flags
      send_pixel(8'd0, 8'd0, 8'd0);         // black, grey class
      send_pixel(8'd255, 8'd255, 8'd255);   // white, grey class
      send_pixel(8'd255, 8'd0, 8'd0);       // pure primaries
      send_pixel(8'd0, 8'd255, 8'd0);
      send_pixel(8'd0, 8'd0, 8'd255);
      send_pixel(8'd255, 8'd255, 8'd0);     // pure secondaries
      send_pixel(8'd255, 8'd0, 8'd255);
      send_pixel(8'd0, 8'd255, 8'd255);
      send_pixel(8'd9, 8'd5, 8'd5);         // ratio exactly 1.8, not dominant
      send_pixel(8'd10, 8'd5, 8'd5);        // just over 1.8, red dominant
      send_pixel(8'd5, 8'd10, 8'd5);
      send_pixel(8'd5, 8'd5, 8'd10);
      send_pixel(8'd200, 8'd10, 8'd150);    // magenta
      send_pixel(8'd200, 8'd150, 8'd10);    // yellow
      send_pixel(8'd10, 8'd150, 8'd200);    // cyan
      send_pixel(8'd180, 8'd10, 8'd100);    // magenta pair right at the ratio edge
      send_pixel(8'd181, 8'd10, 8'd100);    // pair too far apart, red dominant
      send_pixel(8'd100, 8'd100, 8'd100);
      send_pixel(8'd128, 8'd64, 8'd32);
      send_pixel(8'd1, 8'd0, 8'd0);         // smallest dominant channel
      send_pixel(8'd0, 8'd1, 8'd1);         // smallest cyan
      send_pixel(8'd255, 8'd254, 8'd0);
      send_pixel(8'd60, 8'd40, 8'd30);      // red and green close over blue, yellow
      drain_results();

      for (phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase)
            0:       setting = '{default: 1'b1};
            1:       setting = '{default: 1'b0};
            2:       setting = 6'b111000;   // primaries and grey only
            3:       setting = 6'b000111;   // secondaries only
            default: setting = scs_pkg::keep_type'(6'($urandom_range(63)));
         endcase
         write_keep(setting);

         // idling pattern rotates: none, sender idle, receiver stall, both light
         case (phase % 4)
            0: begin
               sender_idle_pct    = 0;
               receiver_stall_pct = 0;
            end
            1: begin
               sender_idle_pct    = 60;
               receiver_stall_pct = 0;
            end
            2: begin
               sender_idle_pct    = 0;
               receiver_stall_pct = 60;
            end
            default: begin
               sender_idle_pct    = 7;
               receiver_stall_pct = 7;
            end
         endcase

         for (n = 0; n < PIXELS_PER_PHASE; n++) begin
            px = random_pixel();
            send_pixel(px.red, px.green, px.blue);
         end
         drain_results();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      if (board.mismatches == 0 && board.pending.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

[sim.f]
src/scs_pkg.sv
src/scs_req_if.sv
src/scs_rsp_if.sv
src/selective_color_sepia_unit.sv
sim/tb_selective_color_sepia_unit.sv
